FILE: hdl/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared types and constants of the radial vignette block.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

  localparam int unsigned CFG_W      = 13;   // width of a configuration register
  localparam int unsigned CFG_IDX_W  = 2;    // width of the register index
  localparam int unsigned CH_W       = 8;    // color channel width
  localparam int unsigned FULL_W     = 18;   // width of 32 * height
  localparam int unsigned FRAC_W     = 16;   // fraction bits of the scale
  localparam int unsigned SCALE_W    = 17;   // scale, 1.0 included

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take the input item, step the position counters
    logic square;     // square both distances
    logic sum;        // add squares, load the root radicand
    logic root_step;  // one bit of the square root
    logic div_init;   // form the numerator and the integer quotient bit
    logic div_step;   // one fraction bit of the scale
    logic write_out;  // apply the scale and load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic zero_scale; // distance at or beyond the radius, or height zero
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/rvd_ctrl.sv
// ----------------------------------------------------------------------------
// rvd_ctrl
// Sequencer of the vignette block: handshakes, step counts, output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_ctrl #(
  parameter int unsigned ROOT_W = 18
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output rvd_pkg::cmd_t   cmd_o,
  input  rvd_pkg::status_t status_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQR   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_ROOT  = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;

  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept;
  logic             out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQR;
        end
      end
      S_SQR: begin
        cmd_o.square = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d     = CNT_W'(ROOT_W - 1);
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = CNT_W'(rvd_pkg::FRAC_W - 1);
        // scale of zero needs no division
        state_d        = status_i.zero_scale ? S_MUL : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.write_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.write_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_SQR)
    else $error("accepted item did not start the square stage");

  a_root_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT && cnt_q == '0) |=> state_q == S_DINIT)
    else $error("square root did not hand over to the divider");

  a_zero_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DINIT && status_i.zero_scale) |=> state_q == S_MUL)
    else $error("zero scale did not skip the division");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_MUL)
    else $error("output valid rose outside the output stage");

endmodule

`default_nettype wire

FILE: hdl/rvd_datapath.sv
// ----------------------------------------------------------------------------
// rvd_datapath
// Position counters, distance squares, bit-serial root and divider, scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_datapath #(
  parameter int unsigned MAX_DIMENSION = 4096,
  parameter int unsigned CNT_POS_W     = 12,
  parameter int unsigned DIFF_W        = 13,
  parameter int unsigned ROOT_W        = 18
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [rvd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [rvd_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire [rvd_pkg::CH_W-1:0]        red_in_i,
  input  wire [rvd_pkg::CH_W-1:0]        green_in_i,
  input  wire [rvd_pkg::CH_W-1:0]        blue_in_i,
  input  wire                            frame_start_i,
  input  rvd_pkg::cmd_t                  cmd_i,
  output rvd_pkg::status_t               status_o,
  output logic [rvd_pkg::CH_W-1:0]       red_out_o,
  output logic [rvd_pkg::CH_W-1:0]       green_out_o,
  output logic [rvd_pkg::CH_W-1:0]       blue_out_o,
  output logic                           frame_end_o
);

  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned FULL_W = rvd_pkg::FULL_W;
  localparam int unsigned CH_W   = rvd_pkg::CH_W;
  localparam int unsigned PROD_W = CH_W + rvd_pkg::SCALE_W;

  // configuration
  logic [rvd_pkg::CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rvd_pkg::WIDTH_RESET;
      height_q <= rvd_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rvd_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        rvd_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position counters
  logic [CNT_POS_W-1:0] col_q, row_q, col_d, row_d, col_eff, row_eff;
  logic [CNT_POS_W:0]   col_inc, row_inc;
  logic                 row_end, frame_last;
  logic [DIFF_W-1:0]    twice_col, twice_row, w_ext, h_ext, dx, dy;

  assign col_eff = frame_start_i ? '0 : col_q;
  assign row_eff = frame_start_i ? '0 : row_q;
  assign col_inc = {1'b0, col_eff} + 1'b1;
  assign row_inc = {1'b0, row_eff} + 1'b1;
  assign w_ext   = DIFF_W'(width_q);
  assign h_ext   = DIFF_W'(height_q);

  assign row_end    = (DIFF_W'(col_inc) >= w_ext) ||
                      (col_inc >= (CNT_POS_W+1)'(MAX_DIMENSION));
  assign frame_last = row_end && ((DIFF_W'(row_inc) >= h_ext) ||
                      (row_inc >= (CNT_POS_W+1)'(MAX_DIMENSION)));

  assign twice_col = DIFF_W'({col_eff, 1'b0});
  assign twice_row = DIFF_W'({row_eff, 1'b0});
  assign dx = (twice_col >= w_ext) ? twice_col - w_ext : w_ext - twice_col;
  assign dy = (twice_row >= h_ext) ? twice_row - h_ext : h_ext - twice_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.load) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_last ? '0 : row_inc[CNT_POS_W-1:0];
      end else begin
        col_d = col_inc[CNT_POS_W-1:0];
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // work registers
  logic [CH_W-1:0]   red_q, green_q, blue_q;
  logic              last_q;
  logic [DIFF_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic [SUM_W-1:0]  dsum;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, full_ext;
  logic [FULL_W-1:0] full, num0, div_q;
  logic [FULL_W:0]   div_sh;
  logic [rvd_pkg::SCALE_W-1:0] scale_q;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  assign dsum     = SUM_W'(sqx_q) + SUM_W'(sqy_q);
  assign rem_sh   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial    = {root_q, 2'b01};
  assign full     = {height_q, 5'b0};
  assign full_ext = ROOT_W'(full);
  assign num0     = FULL_W'(full_ext - root_q);
  assign div_sh   = {div_q, 1'b0};

  assign status_o.zero_scale = (full == '0) || (root_q >= full_ext);

  assign prod_r = PROD_W'(red_q)   * PROD_W'(scale_q);
  assign prod_g = PROD_W'(green_q) * PROD_W'(scale_q);
  assign prod_b = PROD_W'(blue_q)  * PROD_W'(scale_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q   <= red_in_i;
      green_q <= green_in_i;
      blue_q  <= blue_in_i;
      last_q  <= frame_last;
      dx_q    <= dx;
      dy_q    <= dy;
    end
    if (cmd_i.square) begin
      sqx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
      sqy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
    end
    if (cmd_i.sum) begin
      // four fraction bits of the root: radicand carries eight
      rad_q  <= RAD_W'({dsum, 8'b0});
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      if (status_o.zero_scale) begin
        scale_q <= '0;
        div_q   <= '0;
      end else if (num0 >= full) begin
        scale_q <= rvd_pkg::SCALE_W'(1);
        div_q   <= num0 - full;
      end else begin
        scale_q <= '0;
        div_q   <= num0;
      end
    end
    if (cmd_i.div_step) begin
      if (div_sh >= {1'b0, full}) begin
        div_q   <= FULL_W'(div_sh - {1'b0, full});
        scale_q <= {scale_q[rvd_pkg::SCALE_W-2:0], 1'b1};
      end else begin
        div_q   <= div_sh[FULL_W-1:0];
        scale_q <= {scale_q[rvd_pkg::SCALE_W-2:0], 1'b0};
      end
    end
    if (cmd_i.write_out) begin
      red_out_o   <= prod_r[rvd_pkg::FRAC_W +: CH_W];
      green_out_o <= prod_g[rvd_pkg::FRAC_W +: CH_W];
      blue_out_o  <= prod_b[rvd_pkg::FRAC_W +: CH_W];
      frame_end_o <= last_q;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/radial_vignette_darken.sv
// ----------------------------------------------------------------------------
// radial_vignette_darken
// Darkens raster-order RGB pixels by their distance from the frame center.
// ----------------------------------------------------------------------------
// One pixel is in work at a time, from accept to output. The square root
// takes one result bit a cycle; its result is ROOT_W bits wide, where ROOT_W =
// max(clog2(MAX_DIMENSION) + 1, 13) + 5, or 18 at the default MAX_DIMENSION
// of 4096. After a setup step the scale divider takes one quotient bit a
// cycle; a pixel beyond the radius skips the divider. A finished pixel sits
// in the output register, so the next pixel is taken while it waits. Write
// image_width and image_height only while no pixel is in work.
`default_nettype none

module radial_vignette_darken #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [rvd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [rvd_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire [rvd_pkg::CH_W-1:0]      red_in_i,
  input  wire [rvd_pkg::CH_W-1:0]      green_in_i,
  input  wire [rvd_pkg::CH_W-1:0]      blue_in_i,
  input  wire                          frame_start_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [rvd_pkg::CH_W-1:0]     red_out_o,
  output logic [rvd_pkg::CH_W-1:0]     green_out_o,
  output logic [rvd_pkg::CH_W-1:0]     blue_out_o,
  output logic                         frame_end_o
);

  localparam int unsigned CNT_POS_W = $clog2(MAX_DIMENSION);
  localparam int unsigned DIFF_W    = (CNT_POS_W + 1 > rvd_pkg::CFG_W) ?
                                      CNT_POS_W + 1 : rvd_pkg::CFG_W;
  localparam int unsigned ROOT_W    = DIFF_W + 5;

  rvd_pkg::cmd_t    cmd;
  rvd_pkg::status_t status;

  rvd_ctrl #(
    .ROOT_W (ROOT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rvd_datapath #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .CNT_POS_W     (CNT_POS_W),
    .DIFF_W        (DIFF_W),
    .ROOT_W        (ROOT_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .frame_start_i (frame_start_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

`default_nettype wire
